@@ design/qpr_pkg.sv @@
package qpr_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  // product after dropping the fraction: 64 - 16 bits
  localparam int unsigned PROD_W    = 2 * DATA_W - FRAC_BITS;
  // room for a four-term sum, or a three-term sum doubled plus a vector term
  localparam int unsigned ACC_W     = PROD_W + 4;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     ovf;
  } sat_t;

  function automatic sat_t sat_acc(input logic signed [ACC_W-1:0] x);
    sat_t r;
    logic [ACC_W-DATA_W:0] top;
    top = x[ACC_W-1:DATA_W-1];
    if ((top == '0) || (top == '1)) begin
      r.val = x[DATA_W-1:0];
      r.ovf = 1'b0;
    end else begin
      r.val = x[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      r.ovf = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ design/quaternion_product_and_rotate.sv @@
// Quaternion product / vector rotation unit, Q15.16 fixed point.
// Input: an item is taken on each rising edge with start_i high and busy_o low.
// busy_o is always low, so a new item may be issued every cycle.
// mode_i = 0 gives the Hamilton product a*b; mode_i = 1 rotates (b_x,b_y,b_z)
// by a as v + 2*(a_w*(q x v) + q x (q x v)), r_w_o = 0, b_w_i unused.
// The quaternion is not normalized. Components saturate to 32 bits and
// overflow_o flags any saturation, including of the inner cross product.
// Output: done_o is high for exactly one cycle with the result on r_*_o;
// the receiver takes it in that cycle and cannot stall the block.
// The accepted item passes through the valid1_q, valid2_q and valid3_q stages;
// done_o and the result are then registered. Throughput: 1 item per cycle.
// Stages: 16 multipliers, four-term sums and cross-product saturation,
// 9 multipliers for the rotation, final sums and saturation into the output
// registers. The depth is set by the two 32x32 multiplier ranks.
// Reset clears the stage valid bits; items in flight are dropped.
module quaternion_product_and_rotate
  import qpr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     mode_i,
  input  logic signed [DATA_W-1:0] a_w_i,
  input  logic signed [DATA_W-1:0] a_x_i,
  input  logic signed [DATA_W-1:0] a_y_i,
  input  logic signed [DATA_W-1:0] a_z_i,
  input  logic signed [DATA_W-1:0] b_w_i,
  input  logic signed [DATA_W-1:0] b_x_i,
  input  logic signed [DATA_W-1:0] b_y_i,
  input  logic signed [DATA_W-1:0] b_z_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] r_w_o,
  output logic signed [DATA_W-1:0] r_x_o,
  output logic signed [DATA_W-1:0] r_y_o,
  output logic signed [DATA_W-1:0] r_z_o,
  output logic                     overflow_o
);

  // component order in arrays: w, x, y, z (vector arrays: x, y, z)
  logic signed [DATA_W-1:0] a_vec [4];
  logic signed [DATA_W-1:0] b_vec [4];
  logic signed [PROD_W-1:0] p1 [16];

  logic                     valid1_q, mode1_q;
  logic signed [DATA_W-1:0] a1_q [4];
  logic signed [DATA_W-1:0] v1_q [3];

  logic                     valid2_q, mode2_q, ovf2_q, ovf2_d;
  logic signed [DATA_W-1:0] a2_q [4];
  logic signed [DATA_W-1:0] v2_q [3];
  logic signed [ACC_W-1:0]  acc2_q [4], acc2_d [4];
  logic signed [DATA_W-1:0] u2_q [3];
  sat_t                     u_sat [3];

  logic signed [PROD_W-1:0] m3 [9];
  logic                     valid3_q, mode3_q, ovf3_q;
  logic signed [DATA_W-1:0] v3_q [3];
  logic signed [ACC_W-1:0]  acc3_q [4];

  logic signed [ACC_W-1:0]  rot [3];
  sat_t                     fin [4];
  logic                     done_q, done_d, ovf_q, ovf_d;
  logic signed [DATA_W-1:0] rw_q, rx_q, ry_q, rz_q, rw_d, rx_d, ry_d, rz_d;

  assign busy_o = 1'b0;

  assign a_vec[0] = a_w_i;
  assign a_vec[1] = a_x_i;
  assign a_vec[2] = a_y_i;
  assign a_vec[3] = a_z_i;
  assign b_vec[0] = b_w_i;
  assign b_vec[1] = b_x_i;
  assign b_vec[2] = b_y_i;
  assign b_vec[3] = b_z_i;

  // stage 1: every a_i * b_j, product index i*4+j
  for (genvar gi = 0; gi < 4; gi++) begin : g_row
    for (genvar gj = 0; gj < 4; gj++) begin : g_col
      qpr_fmul u_mul (
        .clk_i (clk_i),
        .a_i   (a_vec[gi]),
        .b_i   (b_vec[gj]),
        .p_o   (p1[gi*4+gj])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    mode1_q <= mode_i;
    a1_q    <= a_vec;
    v1_q[0] <= b_x_i;
    v1_q[1] <= b_y_i;
    v1_q[2] <= b_z_i;
  end

  // stage 2: product sums (mode 0) and saturated q x v (mode 1)
  always_comb begin
    acc2_d[0] = ACC_W'(p1[0]) - ACC_W'(p1[5]) - ACC_W'(p1[10]) - ACC_W'(p1[15]);
    acc2_d[1] = ACC_W'(p1[1]) + ACC_W'(p1[4]) + ACC_W'(p1[11]) - ACC_W'(p1[14]);
    acc2_d[2] = ACC_W'(p1[2]) - ACC_W'(p1[7]) + ACC_W'(p1[8]) + ACC_W'(p1[13]);
    acc2_d[3] = ACC_W'(p1[3]) + ACC_W'(p1[6]) - ACC_W'(p1[9]) + ACC_W'(p1[12]);
    u_sat[0]  = sat_acc(ACC_W'(p1[11]) - ACC_W'(p1[14]));
    u_sat[1]  = sat_acc(ACC_W'(p1[13]) - ACC_W'(p1[7]));
    u_sat[2]  = sat_acc(ACC_W'(p1[6]) - ACC_W'(p1[9]));
    ovf2_d    = mode1_q & (u_sat[0].ovf | u_sat[1].ovf | u_sat[2].ovf);
  end

  always_ff @(posedge clk_i) begin
    mode2_q <= mode1_q;
    a2_q    <= a1_q;
    v2_q    <= v1_q;
    acc2_q  <= acc2_d;
    ovf2_q  <= ovf2_d;
    u2_q[0] <= u_sat[0].val;
    u2_q[1] <= u_sat[1].val;
    u2_q[2] <= u_sat[2].val;
  end

  // stage 3: a_w*u and q x u
  qpr_fmul u_m0 (.clk_i(clk_i), .a_i(a2_q[0]), .b_i(u2_q[0]), .p_o(m3[0]));
  qpr_fmul u_m1 (.clk_i(clk_i), .a_i(a2_q[0]), .b_i(u2_q[1]), .p_o(m3[1]));
  qpr_fmul u_m2 (.clk_i(clk_i), .a_i(a2_q[0]), .b_i(u2_q[2]), .p_o(m3[2]));
  qpr_fmul u_m3 (.clk_i(clk_i), .a_i(a2_q[2]), .b_i(u2_q[2]), .p_o(m3[3]));
  qpr_fmul u_m4 (.clk_i(clk_i), .a_i(a2_q[3]), .b_i(u2_q[1]), .p_o(m3[4]));
  qpr_fmul u_m5 (.clk_i(clk_i), .a_i(a2_q[3]), .b_i(u2_q[0]), .p_o(m3[5]));
  qpr_fmul u_m6 (.clk_i(clk_i), .a_i(a2_q[1]), .b_i(u2_q[2]), .p_o(m3[6]));
  qpr_fmul u_m7 (.clk_i(clk_i), .a_i(a2_q[1]), .b_i(u2_q[1]), .p_o(m3[7]));
  qpr_fmul u_m8 (.clk_i(clk_i), .a_i(a2_q[2]), .b_i(u2_q[0]), .p_o(m3[8]));

  always_ff @(posedge clk_i) begin
    mode3_q <= mode2_q;
    v3_q    <= v2_q;
    acc3_q  <= acc2_q;
    ovf3_q  <= ovf2_q;
  end

  // stage 4: final sums, saturation, output registers
  always_comb begin
    rot[0] = ACC_W'(v3_q[0])
           + ((ACC_W'(m3[0]) + ACC_W'(m3[3]) - ACC_W'(m3[4])) <<< 1);
    rot[1] = ACC_W'(v3_q[1])
           + ((ACC_W'(m3[1]) + ACC_W'(m3[5]) - ACC_W'(m3[6])) <<< 1);
    rot[2] = ACC_W'(v3_q[2])
           + ((ACC_W'(m3[2]) + ACC_W'(m3[7]) - ACC_W'(m3[8])) <<< 1);
    if (mode3_q) begin
      fin[0] = '{val: '0, ovf: 1'b0};
      fin[1] = sat_acc(rot[0]);
      fin[2] = sat_acc(rot[1]);
      fin[3] = sat_acc(rot[2]);
    end else begin
      fin[0] = sat_acc(acc3_q[0]);
      fin[1] = sat_acc(acc3_q[1]);
      fin[2] = sat_acc(acc3_q[2]);
      fin[3] = sat_acc(acc3_q[3]);
    end
    rw_d   = fin[0].val;
    rx_d   = fin[1].val;
    ry_d   = fin[2].val;
    rz_d   = fin[3].val;
    ovf_d  = ovf3_q | fin[0].ovf | fin[1].ovf | fin[2].ovf | fin[3].ovf;
    done_d = valid3_q;
  end

  always_ff @(posedge clk_i) begin
    rw_q  <= rw_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    rz_q  <= rz_d;
    ovf_q <= ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      valid1_q <= start_i & ~busy_o;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
      done_q   <= done_d;
    end
  end

  assign done_o     = done_q;
  assign r_w_o      = rw_q;
  assign r_x_o      = rx_q;
  assign r_y_o      = ry_q;
  assign r_z_o      = rz_q;
  assign overflow_o = ovf_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##4 done_o)
    else $error("accepted item did not complete after 4 cycles");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 4))
    else $error("result strobe without an accepted item");

  a_rot_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && mode_i |-> ##4 (r_w_o == '0))
    else $error("rotation result has nonzero scalar part");

  a_inner_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid2_q && ovf2_q |-> ##2 overflow_o)
    else $error("cross product saturation not reported");
`endif

endmodule

@@ design/qpr_fmul.sv @@
// Registered Q15.16 multiply, result floored to Q31.16.
module qpr_fmul
  import qpr_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [2*DATA_W-1:0] prod;
  logic signed [PROD_W-1:0]   p_d, p_q;

  assign prod = (2*DATA_W)'(a_i) * (2*DATA_W)'(b_i);
  // dropping low bits of a two's complement value floors it
  assign p_d  = prod[2*DATA_W-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
